/* src/box_muller_gaussian_sampler_assert.svh */
// Assertion macros for the Gaussian sampler
`ifndef BOX_MULLER_GAUSSIAN_SAMPLER_ASSERT_SVH
`define BOX_MULLER_GAUSSIAN_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BMG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define BMG_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define BMG_ASSERT_IMP(label, ante, cons)
`define BMG_ASSERT_NEVER(label, cond)
`endif
`endif

/* src/bmg_pkg.sv */
// Shared types, constants and tables of the Gaussian sampler
package bmg_pkg;

    typedef struct packed {
        logic [31:0] uniform_a;
        logic [31:0] uniform_b;
    } in_t;

    typedef struct packed {
        logic signed [31:0] gauss_sample;
        logic               saturated;
    } out_t;

    localparam logic CFG_MEAN_OFFSET = 1'b0;
    localparam logic CFG_STD_DEV     = 1'b1;

    localparam logic [30:0] QONE        = 31'h4000_0000;
    localparam logic [25:0] LN2_Q26     = 26'h2C5_C860;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487_ED51;

    localparam int LOG_STEPS    = 32;
    localparam int ROOT_STEPS   = 32;
    localparam int SERIES_STEPS = 6;

    // front 1, log squaring, subtract, ln2 scale, root, then 4 scaling stages
    localparam int LOG_LAT   = LOG_STEPS + 2 + ROOT_STEPS;
    localparam int TRIG_LAT  = 3 * SERIES_STEPS + 2;
    localparam int TOTAL_LAT = 1 + LOG_LAT + 4;

    // Horner divisors; odd selects the sine series
    function automatic logic [7:0] series_div(input logic [2:0] step, input logic odd);
        logic [7:0] k;
        k = 8'd2;
        unique case ({odd, step})
            4'b0_000: k = 8'd132;
            4'b0_001: k = 8'd90;
            4'b0_010: k = 8'd56;
            4'b0_011: k = 8'd30;
            4'b0_100: k = 8'd12;
            4'b0_101: k = 8'd2;
            4'b1_000: k = 8'd156;
            4'b1_001: k = 8'd110;
            4'b1_010: k = 8'd72;
            4'b1_011: k = 8'd42;
            4'b1_100: k = 8'd20;
            4'b1_101: k = 8'd6;
            default:  k = 8'd2;
        endcase
        return k;
    endfunction

    // floor(2^34 / k) for each divisor
    function automatic logic [33:0] series_recip(input logic [2:0] step, input logic odd);
        logic [33:0] m;
        m = 34'd8589934592;
        unique case ({odd, step})
            4'b0_000: m = 34'd130150524;
            4'b0_001: m = 34'd190887435;
            4'b0_010: m = 34'd306783378;
            4'b0_011: m = 34'd572662306;
            4'b0_100: m = 34'd1431655765;
            4'b0_101: m = 34'd8589934592;
            4'b1_000: m = 34'd110127366;
            4'b1_001: m = 34'd156180628;
            4'b1_010: m = 34'd238609294;
            4'b1_011: m = 34'd409044504;
            4'b1_100: m = 34'd858993459;
            4'b1_101: m = 34'd2863311530;
            default:  m = 34'd8589934592;
        endcase
        return m;
    endfunction

endpackage

/* src/box_muller_gaussian_sampler.sv */
// Gaussian sampler top: one sample per cycle.
// Depth is set by the 32 log2 squaring stages and the 32 square-root digit stages.
// busy stays low: a new transaction is taken every cycle; done pulses for one cycle.
// Reset clears all valid bits and sets mean_offset to 0 and std_dev to 1.0.
// No clearing pass; results appear only for transactions started after reset.
`include "box_muller_gaussian_sampler_assert.svh"
module box_muller_gaussian_sampler #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bmg_pkg::in_t   request,
    output logic           done,
    output bmg_pkg::out_t  result,
    input  logic           cfg_write,
    input  logic           cfg_index,
    input  logic [23:0]    cfg_data
);

    localparam int UB = UNIFORM_BITS;
    localparam int PW = $clog2(UB);
    localparam int EW = $clog2(UB + 1);

    logic [23:0] mean_offset_reg;
    logic [23:0] std_dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_offset_reg <= 24'd0;
            std_dev_reg     <= 24'd65536;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bmg_pkg::CFG_MEAN_OFFSET: mean_offset_reg <= cfg_data;
                bmg_pkg::CFG_STD_DEV:     std_dev_reg     <= cfg_data;
                default:                  mean_offset_reg <= mean_offset_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // front stage: clamp, normalize u1, phase to angle
    logic [UB+31:0] a_ext;
    logic [UB+31:0] b_ext;
    logic [UB-1:0]  u1_raw;
    logic [UB-1:0]  u1;
    logic [UB-1:0]  u2;
    logic [PW-1:0]  lead;
    logic [UB-1:0]  norm;
    logic [UB+30:0] norm_w;
    logic [UB+31:0] phase_w;
    logic [31:0]    phase;
    logic [61:0]    aprod;

    assign a_ext  = {{UB{1'b0}}, request.uniform_a};
    assign b_ext  = {{UB{1'b0}}, request.uniform_b};
    assign u1_raw = a_ext[UB-1:0];
    assign u1     = (u1_raw == '0) ? UB'(1) : u1_raw;
    assign u2     = b_ext[UB-1:0];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < UB; i++)
        begin
            if (u1[i])
            begin
                lead = PW'(i);
            end
        end
    end

    assign norm    = u1 << (PW'(UB - 1) - lead);
    assign norm_w  = {norm, 31'b0};
    assign phase_w = {u2, 32'b0};
    assign phase   = phase_w[UB+31 -: 32];
    assign aprod   = {32'b0, phase[29:0]} * {30'b0, bmg_pkg::HALF_PI_Q30};

    logic [30:0]   x_f_reg;
    logic [EW-1:0] expo_f_reg;
    logic [30:0]   angle_f_reg;
    logic [1:0]    quad_f_reg;
    logic          v_f_reg;

    always_ff @(posedge clk)
    begin
        x_f_reg     <= norm_w[UB+30 -: 31];
        expo_f_reg  <= EW'(UB) - EW'(lead);
        angle_f_reg <= aprod[60:30];
        quad_f_reg  <= phase[31:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f_reg <= 1'b0;
        end
        else
        begin
            v_f_reg <= start && !busy;
        end
    end

    logic        log_valid;
    logic [31:0] radius;

    bmg_log_sqrt #(
        .EW (EW)
    ) u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_f_reg),
        .x         (x_f_reg),
        .expo      (expo_f_reg),
        .out_valid (log_valid),
        .r         (radius)
    );

    logic [30:0] trig_cmag;
    logic        trig_neg;
    logic [31:0] trig_d;

    bmg_trig u_trig (
        .clk   (clk),
        .angle (angle_f_reg),
        .quad  (quad_f_reg),
        .cmag  (trig_cmag),
        .neg   (trig_neg)
    );

    bmg_delay #(
        .WIDTH (32),
        .DEPTH (bmg_pkg::LOG_LAT - bmg_pkg::TRIG_LAT)
    ) u_align (
        .clk  (clk),
        .din  ({trig_neg, trig_cmag}),
        .dout (trig_d)
    );

    // scaling stages
    logic [62:0] zprod;
    logic [36:0] z_reg;
    logic        neg1_reg;
    logic [42:0] plo_reg;
    logic [41:0] phi_reg;
    logic        neg2_reg;
    logic [61:0] ssum;
    logic [28:0] smag_reg;
    logic        neg3_reg;
    logic [2:0]  sv_reg;

    assign zprod = {31'b0, radius} * {32'b0, trig_d[30:0]};
    assign ssum  = {1'b0, phi_reg, 19'b0} + {19'b0, plo_reg};

    always_ff @(posedge clk)
    begin
        z_reg    <= zprod[62:26];
        neg1_reg <= trig_d[31];
        plo_reg  <= {19'b0, std_dev_reg} * {24'b0, z_reg[18:0]};
        phi_reg  <= {18'b0, std_dev_reg} * {24'b0, z_reg[36:19]};
        neg2_reg <= neg1_reg;
        smag_reg <= ssum[60:32];
        neg3_reg <= neg2_reg;
    end

    logic signed [34:0] mu_w;
    logic signed [34:0] s_w;
    logic signed [34:0] sum_w;
    logic               over_hi;
    logic               over_lo;

    assign mu_w    = {{11{mean_offset_reg[23]}}, mean_offset_reg};
    assign s_w     = {6'b0, smag_reg};
    assign sum_w   = neg3_reg ? (mu_w - s_w) : (mu_w + s_w);
    assign over_hi = (sum_w > 35'sd2147483647);
    assign over_lo = (sum_w < -35'sd2147483648);

    always_ff @(posedge clk)
    begin
        priority if (over_hi)
        begin
            result.gauss_sample <= 32'sh7FFF_FFFF;
        end
        else if (over_lo)
        begin
            result.gauss_sample <= 32'sh8000_0000;
        end
        else
        begin
            result.gauss_sample <= sum_w[31:0];
        end
        result.saturated <= over_hi || over_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            done   <= 1'b0;
        end
        else
        begin
            sv_reg <= {sv_reg[1:0], log_valid};
            done   <= sv_reg[2];
        end
    end

    logic at_limit;

    assign at_limit = (result.gauss_sample == 32'sh7FFF_FFFF) ||
                      (result.gauss_sample == 32'sh8000_0000);

    `BMG_ASSERT_IMP(a_latency, done, $past(start && !busy, bmg_pkg::TOTAL_LAT))
    `BMG_ASSERT_IMP(a_sat_limit, done && result.saturated, at_limit)
    `BMG_ASSERT_NEVER(a_radius_zero, log_valid && (radius == 32'd0))

endmodule

/* src/bmg_delay.sv */
// Fixed-length register delay line
module bmg_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 46
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* src/bmg_log_sqrt.sv */
// Radius pipeline: log2 by squaring, ln2 scaling, digit-by-digit square root
module bmg_log_sqrt #(
    parameter int EW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [30:0]   x,
    input  logic [EW-1:0] expo,
    output logic          out_valid,
    output logic [31:0]   r
);

    localparam int NSQ = bmg_pkg::LOG_STEPS;
    localparam int NRT = bmg_pkg::ROOT_STEPS;

    logic [30:0]   x_reg    [NSQ];
    logic [31:0]   lf_reg   [NSQ];
    logic [EW-1:0] expo_reg [NSQ];
    logic [NSQ-1:0] sq_v_reg;

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sq
        logic [30:0]   xs;
        logic [31:0]   lfs;
        logic [EW-1:0] es;
        logic          vs;
        logic [61:0]   sq;
        logic [31:0]   sh;
        if (j == 0)
        begin : g_first
            assign xs  = x;
            assign lfs = '0;
            assign es  = expo;
            assign vs  = in_valid;
        end
        else
        begin : g_rest
            assign xs  = x_reg[j-1];
            assign lfs = lf_reg[j-1];
            assign es  = expo_reg[j-1];
            assign vs  = sq_v_reg[j-1];
        end
        assign sq = {31'b0, xs} * {31'b0, xs};
        assign sh = sq[61:30];
        always_ff @(posedge clk)
        begin
            // x >= 2 emits a one and halves
            x_reg[j]    <= sh[31] ? sh[31:1] : sh[30:0];
            lf_reg[j]   <= {lfs[30:0], sh[31]};
            expo_reg[j] <= es;
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[j] <= 1'b0;
            end
            else
            begin
                sq_v_reg[j] <= vs;
            end
        end
    end

    logic [EW+31:0] lmag_reg;
    logic [63:0]    s56_reg;
    logic           lmag_v_reg;
    logic           s56_v_reg;
    logic [EW+31:0] lmag_next;
    logic [63:0]    scale_prod;

    assign lmag_next  = {expo_reg[NSQ-1], 32'b0} - {{EW{1'b0}}, lf_reg[NSQ-1]};
    assign scale_prod = 64'(lmag_reg) * 64'(bmg_pkg::LN2_Q26);

    always_ff @(posedge clk)
    begin
        lmag_reg <= lmag_next;
        s56_reg  <= {1'b0, scale_prod[63:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmag_v_reg <= 1'b0;
            s56_v_reg  <= 1'b0;
        end
        else
        begin
            lmag_v_reg <= sq_v_reg[NSQ-1];
            s56_v_reg  <= lmag_v_reg;
        end
    end

    logic [34:0] rem_reg  [NRT];
    logic [31:0] root_reg [NRT];
    logic [63:0] rad_reg  [NRT];
    logic [NRT-1:0] rt_v_reg;

    for (genvar j = 0; j < NRT; j++)
    begin : g_rt
        logic [34:0] rs;
        logic [31:0] ro;
        logic [63:0] vs;
        logic        vl;
        logic [34:0] cand;
        logic [34:0] trial;
        logic        ge;
        if (j == 0)
        begin : g_first
            assign rs = '0;
            assign ro = '0;
            assign vs = s56_reg;
            assign vl = s56_v_reg;
        end
        else
        begin : g_rest
            assign rs = rem_reg[j-1];
            assign ro = root_reg[j-1];
            assign vs = rad_reg[j-1];
            assign vl = rt_v_reg[j-1];
        end
        assign cand  = {rs[32:0], vs[63:62]};
        assign trial = {1'b0, ro, 2'b01};
        assign ge    = (cand >= trial);
        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= ge ? (cand - trial) : cand;
            root_reg[j] <= {ro[30:0], ge};
            rad_reg[j]  <= {vs[61:0], 2'b00};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[j] <= 1'b0;
            end
            else
            begin
                rt_v_reg[j] <= vl;
            end
        end
    end

    assign r         = root_reg[NRT-1];
    assign out_valid = rt_v_reg[NRT-1];

endmodule

/* src/bmg_trig.sv */
// Angle pipeline: Horner cosine/sine series with constant-divisor steps
module bmg_trig (
    input  logic        clk,
    input  logic [30:0] angle,
    input  logic [1:0]  quad,
    output logic [30:0] cmag,
    output logic        neg
);

    localparam int NS = bmg_pkg::SERIES_STEPS;

    typedef struct packed {
        logic [31:0] a2;
        logic [30:0] a;
        logic        odd;
        logic        neg;
    } tcarry_t;

    tcarry_t     c0_reg;
    logic [61:0] asq;

    assign asq = {31'b0, angle} * {31'b0, angle};

    always_ff @(posedge clk)
    begin
        c0_reg.a2  <= asq[61:30];
        c0_reg.a   <= angle;
        c0_reg.odd <= quad[0];
        c0_reg.neg <= quad[1] ^ quad[0];
    end

    tcarry_t     ca_reg [NS];
    tcarry_t     cb_reg [NS];
    tcarry_t     cc_reg [NS];
    logic [31:0] y_reg  [NS];
    logic [31:0] yb_reg [NS];
    logic [31:0] est_reg[NS];
    logic [30:0] t_reg  [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        tcarry_t     cs;
        logic [30:0] ts;
        logic [62:0] yprod;
        logic [33:0] recip;
        logic [65:0] eprod;
        logic [7:0]  k;
        logic [39:0] back;
        logic [39:0] rem;
        logic [31:0] q;
        if (i == 0)
        begin : g_first
            assign cs = c0_reg;
            assign ts = bmg_pkg::QONE;
        end
        else
        begin : g_rest
            assign cs = cc_reg[i-1];
            assign ts = t_reg[i-1];
        end
        assign yprod = {31'b0, cs.a2} * {32'b0, ts};
        assign recip = bmg_pkg::series_recip(3'(i), ca_reg[i].odd);
        assign eprod = {34'b0, y_reg[i]} * {32'b0, recip};
        assign k     = bmg_pkg::series_div(3'(i), cb_reg[i].odd);
        assign back  = {8'b0, est_reg[i]} * {32'b0, k};
        assign rem   = {8'b0, yb_reg[i]} - back;
        // reciprocal estimate is low by at most one
        assign q     = est_reg[i] + {31'b0, (rem >= {32'b0, k})};
        always_ff @(posedge clk)
        begin
            ca_reg[i]  <= cs;
            y_reg[i]   <= yprod[61:30];
            cb_reg[i]  <= ca_reg[i];
            yb_reg[i]  <= y_reg[i];
            est_reg[i] <= eprod[65:34];
            cc_reg[i]  <= cb_reg[i];
            t_reg[i]   <= (q > {1'b0, bmg_pkg::QONE}) ? 31'b0 : (bmg_pkg::QONE - q[30:0]);
        end
    end

    logic [61:0] sprod;
    logic [31:0] smag;

    assign sprod = {31'b0, cc_reg[NS-1].a} * {31'b0, t_reg[NS-1]};
    assign smag  = sprod[61:30];

    always_ff @(posedge clk)
    begin
        if (cc_reg[NS-1].odd)
        begin
            cmag <= (smag > {1'b0, bmg_pkg::QONE}) ? bmg_pkg::QONE : smag[30:0];
        end
        else
        begin
            cmag <= t_reg[NS-1];
        end
        neg <= cc_reg[NS-1].neg;
    end

endmodule
